[hdl/rsvg_pkg.sv]
// ----------------------------------------------------------------------------
// Rotated sprite vertex generator package
// Shared types, constants and the quarter-wave sine table function.
// ----------------------------------------------------------------------------
package rsvg_pkg;

    localparam int unsigned CFG_INDEX_W     = 2;
    localparam int unsigned CFG_DATA_W      = 17;
    localparam int unsigned SPRITE_CAPACITY = 4096;
    localparam int unsigned UV_ONE          = 65536;
    localparam int unsigned VERTS_PER_SPRITE = 6;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TILE_UV_STEP = 2'd0,
        CFG_SPRITE_LIMIT = 2'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_VERTEX  = 2'd0,
        KIND_DROPPED = 2'd1,
        KIND_FLUSH   = 2'd2
    } t_kind;

    localparam logic [2:0] LAST_SLOT = 3'(VERTS_PER_SPRITE - 1);

    // Entry k of a quarter-wave sine table of 2**bits + 1 entries, Q1.15.
    function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        q;
        logic signed [63:0] sum;
        x    = (PI_HALF_Q30 * 64'(k)) >> bits;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 9; n++) begin
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = ($unsigned(sum) + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[14:0];
    endfunction

endpackage

[hdl/rotated_sprite_vertex_generator.sv]
// ----------------------------------------------------------------------------
// Rotated sprite vertex generator
// Turns sprite descriptions into six textured vertices (two triangles) and
// reports the vertex count of a batch on flush.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        input      i_in_valid / o_in_ready   opcode, centre, size, angle,
//                                                 tile, flips
//  out       output     o_out_valid / i_out_ready position, uv, slot, kind,
//                                                 count, last
//  cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
//  An item passes four register stages (table read, sum, scale, corners)
//  and the output register before its first result. A put gives six
//  output transactions, one per cycle while i_out_ready is high, so the
//  single output port limits the sustained rate of puts; flushes and dropped
//  puts give one each. Stalls on the output back up stage by stage.
//  Synchronous active-low reset clears the counter and valids, presets config.
// ----------------------------------------------------------------------------
module rotated_sprite_vertex_generator
    import rsvg_pkg::*;
#(
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_opcode,
    input  logic signed [15:0]     i_center_x,
    input  logic signed [15:0]     i_center_y,
    input  logic [14:0]            i_half_size,
    input  logic [15:0]            i_angle,
    input  logic [7:0]             i_tile_col,
    input  logic [7:0]             i_tile_row,
    input  logic                   i_flip_x,
    input  logic                   i_flip_y,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [15:0]     o_pos_x,
    output logic signed [15:0]     o_pos_y,
    output logic [16:0]            o_tex_u,
    output logic [16:0]            o_tex_v,
    output logic [2:0]             o_vertex_slot,
    output logic [1:0]             o_result_kind,
    output logic [14:0]            o_vertex_count,
    output logic                   o_last
);

    localparam int unsigned TableLen = (2 ** SINE_TABLE_BITS) + 1;
    localparam int unsigned AddrW    = SINE_TABLE_BITS + 1;
    localparam logic [AddrW-1:0] QuarterN = AddrW'(2 ** SINE_TABLE_BITS);

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 16'sh7fff;
        end else if (v < -18'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic logic [16:0] clamp_uv(input logic [25:0] p);
        return (p > 26'(UV_ONE)) ? 17'(UV_ONE) : p[16:0];
    endfunction

    // Configuration and batch state.
    logic [16:0] r_uv_step;
    logic [12:0] r_limit;
    logic [12:0] r_count;
    logic [12:0] n_count;

    // Quarter-wave table built at elaboration.
    logic [14:0] w_sine_rom [TableLen];
    for (genvar g = 0; g < TableLen; g++) begin : g_rom
        assign w_sine_rom[g] = sine_entry(g, SINE_TABLE_BITS);
    end

    // Stage valids and flow control.
    logic r_v1, r_v2, r_v3, r_v4, r_ov;
    logic w_out_free, w_free4, w_free3, w_free2, w_free1;
    logic w_adv4, w_adv3, w_adv2, w_accept, w_out_fire;

    // Stage 1.
    t_kind              r_s1_kind;
    logic [14:0]        r_s1_count6;
    logic signed [15:0] r_s1_cx, r_s1_cy;
    logic [14:0]        r_s1_half;
    logic [14:0]        r_s1_sin_mag, r_s1_cos_mag;
    logic               r_s1_sin_neg, r_s1_cos_neg;
    logic [25:0]        r_s1_u0p, r_s1_u1p, r_s1_v0p, r_s1_v1p;
    logic               r_s1_fx, r_s1_fy;

    // Stage 2.
    t_kind              r_s2_kind;
    logic [14:0]        r_s2_count6;
    logic signed [15:0] r_s2_cx, r_s2_cy;
    logic [14:0]        r_s2_half;
    logic [15:0]        r_s2_dif_mag, r_s2_sum_mag;
    logic               r_s2_dif_neg, r_s2_sum_neg;
    logic [16:0]        r_s2_u0, r_s2_u1, r_s2_v0, r_s2_v1;

    // Stage 3.
    t_kind              r_s3_kind;
    logic [14:0]        r_s3_count6;
    logic signed [15:0] r_s3_cx, r_s3_cy;
    logic signed [16:0] r_s3_bx, r_s3_by;
    logic [16:0]        r_s3_u0, r_s3_u1, r_s3_v0, r_s3_v1;

    // Stage 4.
    t_kind              r_s4_kind;
    logic [14:0]        r_s4_count6;
    logic signed [15:0] r_s4_px [4];
    logic signed [15:0] r_s4_py [4];
    logic [16:0]        r_s4_u0, r_s4_u1, r_s4_v0, r_s4_v1;

    // Output stage.
    t_kind              r_o_kind;
    logic [14:0]        r_o_count6;
    logic signed [15:0] r_o_px [4];
    logic signed [15:0] r_o_py [4];
    logic [16:0]        r_o_u0, r_o_u1, r_o_v0, r_o_v1;
    logic [2:0]         r_slot;

    // Flow control.
    always_comb begin
        w_out_fire = r_ov && i_out_ready;
        w_out_free = !r_ov || (i_out_ready && o_last);
        w_free4    = !r_v4 || w_out_free;
        w_adv4     = r_v3 && w_free4;
        w_free3    = !r_v3 || w_free4;
        w_adv3     = r_v2 && w_free3;
        w_free2    = !r_v2 || w_free3;
        w_adv2     = r_v1 && w_free2;
        w_free1    = !r_v1 || w_free2;
        w_accept   = i_in_valid && w_free1;
    end

    assign o_in_ready = w_free1;

    // Acceptance decision and table addressing.
    t_kind             w_kind;
    logic [12:0]       w_eff_limit;
    logic [14:0]       w_count6;
    logic [1:0]        w_quad_s, w_quad_c;
    logic [AddrW-1:0]  w_idx, w_addr_s, w_addr_c;

    always_comb begin
        w_eff_limit = (r_limit > 13'(SPRITE_CAPACITY)) ? 13'(SPRITE_CAPACITY) : r_limit;
        w_count6    = (15'(r_count) << 2) + (15'(r_count) << 1);
        n_count     = r_count;
        if (i_opcode) begin
            w_kind  = KIND_FLUSH;
            n_count = '0;
        end else if (r_count >= w_eff_limit) begin
            w_kind  = KIND_DROPPED;
        end else begin
            w_kind  = KIND_VERTEX;
            n_count = r_count + 13'd1;
        end
        w_quad_s = i_angle[15:14];
        w_quad_c = i_angle[15:14] + 2'd1;
        w_idx    = {1'b0, i_angle[13 -: SINE_TABLE_BITS]};
        w_addr_s = w_quad_s[0] ? (QuarterN - w_idx) : w_idx;
        w_addr_c = w_quad_c[0] ? (QuarterN - w_idx) : w_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv_step <= 17'd4096;
            r_limit   <= 13'd4096;
            r_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TILE_UV_STEP: r_uv_step <= i_cfg_data;
                    CFG_SPRITE_LIMIT: r_limit   <= i_cfg_data[12:0];
                    default:          ;
                endcase
            end
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_free1) r_v1 <= i_in_valid;
            if (w_free2) r_v2 <= r_v1;
            if (w_free3) r_v3 <= r_v2;
            if (w_free4) r_v4 <= r_v3;
            if (w_out_free) r_ov <= r_v4;
        end
    end

    // Stage 1: table read and UV products.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_kind    <= w_kind;
            r_s1_count6  <= w_count6;
            r_s1_cx      <= i_center_x;
            r_s1_cy      <= i_center_y;
            r_s1_half    <= i_half_size;
            r_s1_sin_mag <= w_sine_rom[w_addr_s];
            r_s1_cos_mag <= w_sine_rom[w_addr_c];
            r_s1_sin_neg <= w_quad_s[1];
            r_s1_cos_neg <= w_quad_c[1];
            r_s1_u0p     <= 26'(i_tile_col) * 26'(r_uv_step);
            r_s1_u1p     <= 26'(9'(i_tile_col) + 9'd1) * 26'(r_uv_step);
            r_s1_v0p     <= 26'(i_tile_row) * 26'(r_uv_step);
            r_s1_v1p     <= 26'(9'(i_tile_row) + 9'd1) * 26'(r_uv_step);
            r_s1_fx      <= i_flip_x;
            r_s1_fy      <= i_flip_y;
        end
    end

    // Stage 2: cos - sin and sin + cos, UV clamp and flip.
    logic signed [16:0] w_s, w_c, w_dif, w_sum;
    logic [16:0]        w_u0, w_u1, w_v0, w_v1;

    always_comb begin
        w_s   = r_s1_sin_neg ? -$signed({2'b00, r_s1_sin_mag}) : $signed({2'b00, r_s1_sin_mag});
        w_c   = r_s1_cos_neg ? -$signed({2'b00, r_s1_cos_mag}) : $signed({2'b00, r_s1_cos_mag});
        w_dif = w_c - w_s;
        w_sum = w_s + w_c;
        w_u0  = clamp_uv(r_s1_u0p);
        w_u1  = clamp_uv(r_s1_u1p);
        w_v0  = clamp_uv(r_s1_v0p);
        w_v1  = clamp_uv(r_s1_v1p);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_s2_kind    <= r_s1_kind;
            r_s2_count6  <= r_s1_count6;
            r_s2_cx      <= r_s1_cx;
            r_s2_cy      <= r_s1_cy;
            r_s2_half    <= r_s1_half;
            r_s2_dif_neg <= w_dif[16];
            r_s2_sum_neg <= w_sum[16];
            r_s2_dif_mag <= w_dif[16] ? 16'(-w_dif) : w_dif[15:0];
            r_s2_sum_mag <= w_sum[16] ? 16'(-w_sum) : w_sum[15:0];
            r_s2_u0      <= r_s1_fx ? w_u1 : w_u0;
            r_s2_u1      <= r_s1_fx ? w_u0 : w_u1;
            r_s2_v0      <= r_s1_fy ? w_v1 : w_v0;
            r_s2_v1      <= r_s1_fy ? w_v0 : w_v1;
        end
    end

    // Stage 3: scale by radius with rounding half away from zero.
    logic [31:0] w_bx_rnd, w_by_rnd;
    logic [16:0] w_bx_mag, w_by_mag;

    always_comb begin
        w_bx_rnd = 32'(r_s2_dif_mag) * 32'(r_s2_half) + 32'd16384;
        w_by_rnd = 32'(r_s2_sum_mag) * 32'(r_s2_half) + 32'd16384;
        w_bx_mag = 17'(w_bx_rnd >> 15);
        w_by_mag = 17'(w_by_rnd >> 15);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_s3_kind   <= r_s2_kind;
            r_s3_count6 <= r_s2_count6;
            r_s3_cx     <= r_s2_cx;
            r_s3_cy     <= r_s2_cy;
            r_s3_bx     <= r_s2_dif_neg ? -$signed(w_bx_mag) : $signed(w_bx_mag);
            r_s3_by     <= r_s2_sum_neg ? -$signed(w_by_mag) : $signed(w_by_mag);
            r_s3_u0     <= r_s2_u0;
            r_s3_u1     <= r_s2_u1;
            r_s3_v0     <= r_s2_v0;
            r_s3_v1     <= r_s2_v1;
        end
    end

    // Stage 4: corner positions A, B, C, D with saturation.
    logic signed [17:0] w_cx, w_cy, w_bx, w_by;

    always_comb begin
        w_cx = 18'(r_s3_cx);
        w_cy = 18'(r_s3_cy);
        w_bx = 18'(r_s3_bx);
        w_by = 18'(r_s3_by);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_s4_kind   <= r_s3_kind;
            r_s4_count6 <= r_s3_count6;
            r_s4_px[0]  <= sat16(w_cx - w_by);
            r_s4_py[0]  <= sat16(w_cy + w_bx);
            r_s4_px[1]  <= sat16(w_cx + w_bx);
            r_s4_py[1]  <= sat16(w_cy + w_by);
            r_s4_px[2]  <= sat16(w_cx - w_bx);
            r_s4_py[2]  <= sat16(w_cy - w_by);
            r_s4_px[3]  <= sat16(w_cx + w_by);
            r_s4_py[3]  <= sat16(w_cy - w_bx);
            r_s4_u0     <= r_s3_u0;
            r_s4_u1     <= r_s3_u1;
            r_s4_v0     <= r_s3_v0;
            r_s4_v1     <= r_s3_v1;
        end
    end

    // Output stage: holds one item and steps through its vertices.
    always_ff @(posedge i_clk) begin
        if (w_out_free && r_v4) begin
            r_o_kind   <= r_s4_kind;
            r_o_count6 <= r_s4_count6;
            r_o_px     <= r_s4_px;
            r_o_py     <= r_s4_py;
            r_o_u0     <= r_s4_u0;
            r_o_u1     <= r_s4_u1;
            r_o_v0     <= r_s4_v0;
            r_o_v1     <= r_s4_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (w_out_fire) begin
            r_slot <= o_last ? 3'd0 : r_slot + 3'd1;
        end
    end

    // Slot order A, B, C, D, C, B.
    logic [1:0] w_corner;
    logic       w_is_vertex;

    always_comb begin
        case (r_slot)
            3'd0:    w_corner = 2'd0;
            3'd1:    w_corner = 2'd1;
            3'd2:    w_corner = 2'd2;
            3'd3:    w_corner = 2'd3;
            3'd4:    w_corner = 2'd2;
            default: w_corner = 2'd1;
        endcase
        w_is_vertex    = (r_o_kind == KIND_VERTEX);
        o_out_valid    = r_ov;
        o_result_kind  = r_o_kind;
        o_pos_x        = w_is_vertex ? r_o_px[w_corner] : '0;
        o_pos_y        = w_is_vertex ? r_o_py[w_corner] : '0;
        o_tex_u        = w_is_vertex ? (w_corner[0] ? r_o_u1 : r_o_u0) : '0;
        o_tex_v        = w_is_vertex ? (w_corner[1] ? r_o_v1 : r_o_v0) : '0;
        o_vertex_slot  = w_is_vertex ? r_slot : '0;
        o_vertex_count = (r_o_kind == KIND_FLUSH) ? r_o_count6 : '0;
        o_last         = !w_is_vertex || (r_slot == LAST_SLOT);
    end

    a_single_result_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind != KIND_VERTEX) |-> o_last)
        else $error("non-vertex result without last");

    a_vertex_last_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_VERTEX) |-> (o_last == (o_vertex_slot == LAST_SLOT)))
        else $error("last flag does not match final vertex slot");

    a_slot_steps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=>
        (o_out_valid && o_vertex_slot == 3'($past(o_vertex_slot) + 3'd1)))
        else $error("vertex slot did not advance");

    a_flush_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_opcode) |=> (r_count == 13'd0))
        else $error("flush did not clear sprite count");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_opcode) |=> (r_count <= 13'(SPRITE_CAPACITY)))
        else $error("sprite count passed capacity");

endmodule

[tb/sv/rsvg_tb_pkg.sv]
// ----------------------------------------------------------------------------
// Sprite vertex generator testbench package
// Opcode and register index names shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package rsvg_tb_pkg;

    typedef enum logic {
        OP_PUT   = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    // No register lives at this index, so a write to it must change nothing.
    localparam logic [1:0] CFG_INDEX_SPARE = 2'd3;

endpackage

[tb/sv/rsvg_checker.sv]
// ----------------------------------------------------------------------------
// Sprite vertex generator checker
// Watches the configuration port and both channels, predicts the vertices,
// drop flags and flush reports of every accepted transaction, and compares
// each accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module rsvg_checker
    import rsvg_pkg::*;
    import rsvg_tb_pkg::*;
#(
    parameter int unsigned TABLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic                   i_opcode,
    input  logic signed [15:0]     i_center_x,
    input  logic signed [15:0]     i_center_y,
    input  logic [14:0]            i_half_size,
    input  logic [15:0]            i_angle,
    input  logic [7:0]             i_tile_col,
    input  logic [7:0]             i_tile_row,
    input  logic                   i_flip_x,
    input  logic                   i_flip_y,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic signed [15:0]     i_pos_x,
    input  logic signed [15:0]     i_pos_y,
    input  logic [16:0]            i_tex_u,
    input  logic [16:0]            i_tex_v,
    input  logic [2:0]             i_vertex_slot,
    input  logic [1:0]             i_result_kind,
    input  logic [14:0]            i_vertex_count,
    input  logic                   i_last,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUARTER = 1 << TABLE_BITS;

    typedef struct {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [2:0]         slot;
        t_kind              kind;
        logic [14:0]        count;
        logic               last;
    } t_vertex;

    t_vertex     expected_q[$];
    int          sine_table[QUARTER+1];
    logic [16:0] uv_step;
    logic [12:0] limit_reg;
    logic [12:0] sprites_held;
    int          fail_total    = 0;
    int          result_total  = 0;
    int          pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;
    assign o_checked    = result_total;

    // Quarter-wave sine entry in Q1.15 from a truncating Q30 Taylor series.
    function automatic int quarter_sine(int unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint unsigned q;
        longint          acc;
        x    = (PI_HALF_Q30 * 64'(k)) >> TABLE_BITS;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 9; n++) begin
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        q = ($unsigned(acc) + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return int'(q);
    endfunction

    initial begin
        for (int k = 0; k <= QUARTER; k++) begin
            sine_table[k] = quarter_sine(k);
        end
    end

    function automatic int sine_of(logic [15:0] a);
        int unsigned idx;
        int          v;
        idx = int'(a[13:0]) >> (14 - TABLE_BITS);
        v   = a[14] ? sine_table[QUARTER - idx] : sine_table[idx];
        return a[15] ? -v : v;
    endfunction

    // Q1.15 times radius, back to Q12.4, rounding half away from zero.
    function automatic int scale_radius(int d, int unsigned r);
        longint unsigned m;
        m = (d < 0) ? longint'(-d) : longint'(d);
        m = (m * r + 64'd16384) >> 15;
        return (d < 0) ? -int'(m) : int'(m);
    endfunction

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    function automatic logic [16:0] tile_uv(int unsigned idx);
        longint unsigned v;
        v = longint'(idx) * uv_step;
        return (v > UV_ONE) ? 17'(UV_ONE) : 17'(v);
    endfunction

    function automatic t_vertex blank_result(t_kind kind);
        t_vertex vx;
        vx.pos_x = '0;
        vx.pos_y = '0;
        vx.tex_u = '0;
        vx.tex_v = '0;
        vx.slot  = '0;
        vx.kind  = kind;
        vx.count = '0;
        vx.last  = 1'b1;
        return vx;
    endfunction

    task automatic queue_sprite();
        logic [16:0] u0;
        logic [16:0] u1;
        logic [16:0] v0;
        logic [16:0] v1;
        logic [16:0] swap;
        int          s;
        int          c;
        int          bx;
        int          by;
        int          px[4];
        int          py[4];
        logic [16:0] pu[4];
        logic [16:0] pv[4];
        int          corner;
        t_vertex     vx;
        u0 = tile_uv(i_tile_col);
        u1 = tile_uv(int'(i_tile_col) + 1);
        v0 = tile_uv(i_tile_row);
        v1 = tile_uv(int'(i_tile_row) + 1);
        if (i_flip_x) begin
            swap = u0;
            u0   = u1;
            u1   = swap;
        end
        if (i_flip_y) begin
            swap = v0;
            v0   = v1;
            v1   = swap;
        end
        s  = sine_of(i_angle);
        c  = sine_of(i_angle + 16'd16384);
        bx = scale_radius(c - s, i_half_size);
        by = scale_radius(s + c, i_half_size);
        px[0] = i_center_x - by;  py[0] = i_center_y + bx;  pu[0] = u0;  pv[0] = v0;
        px[1] = i_center_x + bx;  py[1] = i_center_y + by;  pu[1] = u1;  pv[1] = v0;
        px[2] = i_center_x - bx;  py[2] = i_center_y - by;  pu[2] = u0;  pv[2] = v1;
        px[3] = i_center_x + by;  py[3] = i_center_y - bx;  pu[3] = u1;  pv[3] = v1;
        // The second triangle walks back through C and B after D.
        for (int k = 0; k < VERTS_PER_SPRITE; k++) begin
            corner   = (k < 4) ? k : VERTS_PER_SPRITE - k;
            vx.pos_x = clamp16(px[corner]);
            vx.pos_y = clamp16(py[corner]);
            vx.tex_u = pu[corner];
            vx.tex_v = pv[corner];
            vx.slot  = 3'(k);
            vx.kind  = KIND_VERTEX;
            vx.count = '0;
            vx.last  = (3'(k) == LAST_SLOT);
            expected_q.push_back(vx);
        end
    endtask

    task automatic take_item();
        t_vertex     vx;
        logic [12:0] limit;
        if (i_opcode == OP_FLUSH) begin
            vx       = blank_result(KIND_FLUSH);
            vx.count = 15'(int'(sprites_held) * VERTS_PER_SPRITE);
            expected_q.push_back(vx);
            sprites_held = '0;
        end else begin
            limit = (limit_reg > SPRITE_CAPACITY) ? 13'(SPRITE_CAPACITY) : limit_reg;
            if (sprites_held >= limit) begin
                expected_q.push_back(blank_result(KIND_DROPPED));
            end else begin
                queue_sprite();
                sprites_held = sprites_held + 13'd1;
            end
        end
    endtask

    task automatic report_error(string msg);
        $display("checker: %0t ns: %s", $time, msg);
        fail_total++;
    endtask

    task automatic compare_field(string name, logic [16:0] got, logic [16:0] want);
        if (got !== want) begin
            report_error($sformatf("result %0d, %s: got %0h, expected %0h",
                                   result_total, name, got, want));
        end
    endtask

    task automatic check_result();
        t_vertex want;
        if (expected_q.size() == 0) begin
            report_error($sformatf("result %0d arrived with nothing expected", result_total));
        end else begin
            want = expected_q.pop_front();
            compare_field("pos_x", 17'(i_pos_x), 17'(want.pos_x));
            compare_field("pos_y", 17'(i_pos_y), 17'(want.pos_y));
            compare_field("tex_u", i_tex_u, want.tex_u);
            compare_field("tex_v", i_tex_v, want.tex_v);
            compare_field("vertex_slot", 17'(i_vertex_slot), 17'(want.slot));
            compare_field("result_kind", 17'(i_result_kind), 17'(want.kind));
            compare_field("vertex_count", 17'(i_vertex_count), 17'(want.count));
            compare_field("last", 17'(i_last), 17'(want.last));
        end
        result_total++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            uv_step      = 17'd4096;
            limit_reg    = 13'd4096;
            sprites_held = '0;
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TILE_UV_STEP: uv_step = i_cfg_data;
                    CFG_SPRITE_LIMIT: limit_reg = i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                take_item();
            end
        end
        pending_total = expected_q.size();
    end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Sprite vertex generator testbench
// Drives directed and random sprite and flush transactions through several
// register settings, with random idling on both channels, one long output
// stall and one stretch without idling; the checker judges every result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsvg_pkg::*;
    import rsvg_tb_pkg::*;

    localparam int TABLE_BITS   = 10;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        t_opcode            op;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [14:0]        size;
        logic [15:0]        angle;
        logic [7:0]         col;
        logic [7:0]         row;
        logic               fx;
        logic               fy;
    } t_sprite_cmd;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   i_opcode    = 1'b0;
    logic signed [15:0]     i_center_x  = '0;
    logic signed [15:0]     i_center_y  = '0;
    logic [14:0]            i_half_size = '0;
    logic [15:0]            i_angle     = '0;
    logic [7:0]             i_tile_col  = '0;
    logic [7:0]             i_tile_row  = '0;
    logic                   i_flip_x    = 1'b0;
    logic                   i_flip_y    = 1'b0;
    logic                   i_out_ready = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic signed [15:0]     o_pos_x;
    logic signed [15:0]     o_pos_y;
    logic [16:0]            o_tex_u;
    logic [16:0]            o_tex_v;
    logic [2:0]             o_vertex_slot;
    logic [1:0]             o_result_kind;
    logic [14:0]            o_vertex_count;
    logic                   o_last;

    int fail_count;
    int pending;
    int checked;
    bit calm          = 1'b0;
    bit pressure      = 1'b0;
    bit held_once     = 1'b0;
    int items_sent    = 0;
    int flushes_sent  = 0;
    int settings_used = 0;

    rotated_sprite_vertex_generator #(
        .SINE_TABLE_BITS(TABLE_BITS)
    ) dut (.*);

    rsvg_checker #(
        .TABLE_BITS(TABLE_BITS)
    ) u_checker (
        .i_in_ready     (o_in_ready),
        .i_out_valid    (o_out_valid),
        .i_pos_x        (o_pos_x),
        .i_pos_y        (o_pos_y),
        .i_tex_u        (o_tex_u),
        .i_tex_v        (o_tex_v),
        .i_vertex_slot  (o_vertex_slot),
        .i_result_kind  (o_result_kind),
        .i_vertex_count (o_vertex_count),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .*
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("tb: errors");
        $finish;
    end

    // Output side: random back-pressure, one long hold-off while the
    // sender keeps offering so that the block fills up and stalls its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (pressure && !held_once) begin
                held_once = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 26);
            end
        end
    end

    function automatic t_sprite_cmd make_put(logic signed [15:0] cx, logic signed [15:0] cy,
                                             logic [14:0] size, logic [15:0] angle,
                                             logic [7:0] col, logic [7:0] row,
                                             logic fx, logic fy);
        t_sprite_cmd c;
        c.op    = OP_PUT;
        c.cx    = cx;
        c.cy    = cy;
        c.size  = size;
        c.angle = angle;
        c.col   = col;
        c.row   = row;
        c.fx    = fx;
        c.fy    = fy;
        return c;
    endfunction

    function automatic t_sprite_cmd random_put();
        t_sprite_cmd c;
        c = make_put(16'($urandom), 16'($urandom), 15'($urandom), 16'($urandom),
                     8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        case ($urandom_range(9))
            0: c.cx = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: c.cy = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            2: c.size = $urandom_range(1) ? 15'h7FFF : 15'h0000;
            3: c.angle = {2'($urandom), 14'h0} + 16'($urandom_range(2)) - 16'd1;
            4, 5, 6: begin
                c.col = 8'($urandom_range(20));
                c.row = 8'($urandom_range(20));
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic send_item(t_sprite_cmd c);
        if (!calm && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_opcode    <= c.op;
        i_center_x  <= c.cx;
        i_center_y  <= c.cy;
        i_half_size <= c.size;
        i_angle     <= c.angle;
        i_tile_col  <= c.col;
        i_tile_row  <= c.row;
        i_flip_x    <= c.fx;
        i_flip_y    <= c.fy;
        i_in_valid  <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (c.op == OP_FLUSH) begin
            flushes_sent++;
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [16:0] step, logic [12:0] limit);
        write_reg(CFG_TILE_UV_STEP, step);
        write_reg(CFG_SPRITE_LIMIT, {4'($urandom), limit});
        settings_used++;
    endtask

    task automatic run_phase(logic [16:0] step, logic [12:0] limit, int count, int flush_pct);
        t_sprite_cmd c;
        apply_setting(step, limit);
        repeat (count) begin
            c = random_put();
            if ($urandom_range(99) < flush_pct) begin
                c.op = OP_FLUSH;
            end
            send_item(c);
        end
        settle();
    endtask

    initial begin
        t_sprite_cmd flush_cmd;
        flush_cmd    = make_put(0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
        flush_cmd.op = OP_FLUSH;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(flush_cmd);
        send_item(make_put(0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        send_item(make_put(16'sh7FFF, 16'sh7FFF, 15'h7FFF, 0, 255, 255, 1'b0, 1'b0));
        send_item(make_put(16'sh8000, 16'sh8000, 15'h7FFF, 16'd16384, 0, 0, 1'b1, 1'b0));
        send_item(make_put(100, -100, 1000, 16'd32768, 3, 5, 1'b0, 1'b1));
        send_item(make_put(-5, 7, 500, 16'd49152, 15, 15, 1'b1, 1'b1));
        send_item(make_put(0, 0, 15'h7FFF, 16'hFFFF, 16, 16, 1'b0, 1'b0));
        send_item(make_put(1234, -4321, 16384, 16'd8192, 7, 200, 1'b1, 1'b1));
        send_item(make_put(0, 0, 1, 16'd21845, 1, 2, 1'b0, 1'b1));
        send_item(make_put(16'sh8000, 16'sh7FFF, 0, 16'd40000, 128, 64, 1'b1, 1'b0));
        send_item(flush_cmd);
        settle();

        apply_setting(17'd65536, 13'd2);
        send_item(make_put(50, 60, 300, 16'd1000, 0, 0, 1'b1, 1'b0));
        send_item(make_put(-50, -60, 300, 16'd60000, 1, 0, 1'b0, 1'b1));
        send_item(make_put(0, 0, 300, 16'd3000, 0, 0, 1'b0, 1'b0));
        send_item(flush_cmd);
        settle();

        apply_setting(17'd0, 13'h1FFF);
        send_item(make_put(10, 20, 2000, 16'd5000, 9, 9, 1'b1, 1'b1));
        settle();
        write_reg(CFG_INDEX_SPARE, 17'h1FFFF);
        send_item(make_put(-10, -20, 2000, 16'd5000, 9, 9, 1'b0, 1'b0));
        send_item(flush_cmd);
        settle();

        apply_setting(17'h1FFFF, 13'd1);
        send_item(make_put(0, 0, 100, 16'd12345, 0, 0, 1'b1, 1'b0));
        send_item(make_put(0, 0, 100, 16'd12345, 0, 0, 1'b0, 1'b0));
        send_item(flush_cmd);
        settle();

        apply_setting(17'd1, 13'd0);
        send_item(make_put(1, 1, 1, 1, 255, 255, 1'b0, 1'b0));
        send_item(flush_cmd);
        settle();

        calm = 1'b1;
        run_phase(17'd4096, 13'd4096, 100, 6);
        calm     = 1'b0;
        pressure = 1'b1;
        run_phase(17'd65536, 13'h1FFF, 100, 8);
        pressure = 1'b0;
        run_phase(17'd1, 13'd5, 100, 15);
        run_phase(17'($urandom_range(1, 65536)), 13'($urandom_range(1, 30)), 100, 10);
        run_phase(17'($urandom), 13'($urandom), 40, 10);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("summary: %0d transactions sent (%0d flushes), %0d results checked",
                 items_sent, flushes_sent, checked);
        $display("summary: %0d register settings, including zero and all-ones values",
                 settings_used);
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
